@@ design/gsp_pkg.sv @@
// ---------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the gas sensor concentration block
// Sequencer states, unit return codes, register indexes and fixed-point
// widths used by gas_sensor_ppm_from_adc.
// ---------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  // samples averaged into one result
  localparam int SAMPLES_DEF = 5;

  // datapath widths
  localparam int DVD_W = 40;   // divider dividend / quotient
  localparam int DVS_W = 20;   // divider divisor / remainder
  localparam int LOG_W = 21;   // signed log10, Q.16
  localparam int E_W   = 48;   // signed exponent and line offset
  localparam int ACC_W = 56;   // wide product accumulator

  // floor(log10(2) * 2^32)
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

  // register indexes
  localparam logic [2:0] CFG_LOAD = 3'd0;
  localparam logic [2:0] CFG_R0   = 3'd1;
  localparam logic [2:0] CFG_X0   = 3'd2;
  localparam logic [2:0] CFG_X1   = 3'd3;
  localparam logic [2:0] CFG_Y0   = 3'd4;
  localparam logic [2:0] CFG_Y1   = 3'd5;

  // register reset values
  localparam logic [15:0] LOAD_RST = 16'd10000;
  localparam logic [15:0] R0_RST   = 16'd1126;
  localparam logic [15:0] X0_RST   = 16'd200;
  localparam logic [15:0] X1_RST   = 16'd10000;
  localparam logic [15:0] Y0_RST   = 16'd768;
  localparam logic [15:0] Y1_RST   = 16'd256;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_EQX  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_MUL,
    ST_DIV,
    ST_DIV_END,
    ST_COUNT,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LOG_SCALE,
    ST_LOG_END,
    ST_WM_LO,
    ST_WM_HI,
    ST_WM_END,
    ST_DONE
  } state_e;

  // what a finished division feeds
  typedef enum logic [1:0] {
    DR_RS,
    DR_MEAN,
    DR_RATIO,
    DR_SLOPE
  } div_ret_e;

  // where a finished log goes
  typedef enum logic [2:0] {
    LT_X0,
    LT_X1,
    LT_Y0,
    LT_Y1,
    LT_RATIO,
    LT_CAND
  } log_tgt_e;

  // which wide product is being formed
  typedef enum logic {
    WM_COORD,
    WM_E
  } wm_e;

endpackage

`default_nettype wire

@@ design/gas_sensor_ppm_from_adc.sv @@
// ---------------------------------------------------------------------------
// gas_sensor_ppm_from_adc: gas concentration from resistive sensor readings
// Converts 10-bit divider readings to sensor resistance, averages a group
// of readings and evaluates a power-law calibration curve in fixed point.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_ready_o): one converter reading and its
//    channel per item. Ready is high only while the sequencer is idle.
//  - Output channel (out_valid_o / out_ready_i): one result per group of
//    SAMPLES readings: concentration, mean resistance, channel, status.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//    write only while the block is idle.
//  - Sequence: a nonzero reading passes from accept to the next accept through
//    a multiply state, the 40-step restoring divider (one quotient bit per
//    cycle) and the division-end and count states; a zero reading goes
//    straight to the count state. The last reading of a group adds two more
//    divisions, 25 logarithms (normalize, 16 squarings on the shared 32x32
//    multiplier, scale), a slope division and four partial products. A group
//    that ends with a status code stops after the four calibration logarithms.
//  - The result sits in an output register; if the receiver stalls, the
//    sequencer holds the next result until the register frees up, then
//    returns to idle.
//  - Reset clears the accumulator, counters and output valid and loads the
//    register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module gas_sensor_ppm_from_adc #(
  parameter int SAMPLES = gsp_pkg::SAMPLES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // readings
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [9:0]  sample_i,
  input  wire logic [2:0]  channel_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [19:0]      concentration_o,
  output logic [23:0]      mean_kohm_o,
  output logic [2:0]       channel_out_o,
  output logic [1:0]       status_o
);

  localparam int DVD_W = gsp_pkg::DVD_W;
  localparam int DVS_W = gsp_pkg::DVS_W;
  localparam int LOG_W = gsp_pkg::LOG_W;
  localparam int E_W   = gsp_pkg::E_W;
  localparam int ACC_W = gsp_pkg::ACC_W;

  // registers
  logic [15:0] load_q, r0_q, x0_q, x1_q, y0_q, y1_q;
  gsp_pkg::state_e   state_q, state_d;
  gsp_pkg::div_ret_e ret_q, ret_d;
  gsp_pkg::log_tgt_e tgt_q, tgt_d;
  gsp_pkg::wm_e      wm_q, wm_d;

  logic [9:0]  raw_q, raw_d;
  logic [2:0]  chan_q, chan_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] sum_q, sum_d;
  logic        zero_q, zero_d;

  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [5:0]       step_q, step_d;

  logic [30:0] m_q, m_d;
  logic [4:0]  p_q, p_d;
  logic [15:0] frac_q, frac_d;
  logic signed [LOG_W-1:0] res_q, res_d;
  logic signed [LOG_W-1:0] lx0_q, lx0_d, lx1_q, lx1_d, ly0_q, ly0_d, lr_q, lr_d;

  logic [31:0] mean_q, mean_d;
  logic [15:0] ratio_q, ratio_d;
  logic [35:0] smag_q, smag_d;
  logic        sneg_q, sneg_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic signed [E_W-1:0] e_q, e_d;
  logic [19:0] conc_q, conc_d;
  logic [4:0]  bit_q, bit_d;

  logic        out_valid_q;
  logic [19:0] out_conc_q;
  logic [23:0] out_mean_q;
  logic [2:0]  out_chan_q;
  logic [1:0]  out_stat_q;

  // control
  logic in_acc, out_free, div_last, sq_last, grp_done, no_fit, load_out;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // helpers
  logic [DVS_W:0]   dv_shift;
  logic             dv_ge;
  logic [31:0]      sq;
  logic [5:0]       pexp;
  logic [21:0]      l2, l2mag;
  logic [LOG_W-1:0] pr;
  logic [21:0]      dy, dx, dymag, dxmag;
  logic [LOG_W-1:0] opv, opmag;
  logic             opneg;
  logic [39:0]      tmag;
  logic [E_W-1:0]   term;
  logic [19:0]      cand, cnew;
  logic             keep;
  logic [1:0]       stat;
  // launch requests
  logic             do_div, do_log;
  logic [DVD_W-1:0] l_dvd;
  logic [DVS_W-1:0] l_dvs;
  gsp_pkg::div_ret_e l_ret;
  logic [19:0]      l_x;
  gsp_pkg::log_tgt_e l_tgt;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= gsp_pkg::LOAD_RST;
      r0_q   <= gsp_pkg::R0_RST;
      x0_q   <= gsp_pkg::X0_RST;
      x1_q   <= gsp_pkg::X1_RST;
      y0_q   <= gsp_pkg::Y0_RST;
      y1_q   <= gsp_pkg::Y1_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsp_pkg::CFG_LOAD: load_q <= cfg_data_i;
        gsp_pkg::CFG_R0:   r0_q   <= cfg_data_i;
        gsp_pkg::CFG_X0:   x0_q   <= cfg_data_i;
        gsp_pkg::CFG_X1:   x1_q   <= cfg_data_i;
        gsp_pkg::CFG_Y0:   y0_q   <= cfg_data_i;
        gsp_pkg::CFG_Y1:   y1_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // status flags
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign div_last = (step_q == 6'(DVD_W - 1));
  assign sq_last  = (step_q == 6'd15);
  assign grp_done = ((cnt_q + 3'd1) == 3'(SAMPLES));
  assign no_fit   = zero_q || (lx0_q == lx1_q);
  assign stat     = zero_q ? gsp_pkg::STAT_ZERO :
                    (lx0_q == lx1_q) ? gsp_pkg::STAT_EQX : gsp_pkg::STAT_OK;
  assign load_out = (state_q == gsp_pkg::ST_DONE) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsp_pkg::ST_IDLE:
        if (in_acc) state_d = (sample_i == 10'd0) ? gsp_pkg::ST_COUNT : gsp_pkg::ST_RS_MUL;
      gsp_pkg::ST_RS_MUL: state_d = gsp_pkg::ST_DIV;
      gsp_pkg::ST_DIV:
        if (div_last) state_d = gsp_pkg::ST_DIV_END;
      gsp_pkg::ST_DIV_END: begin
        unique case (ret_q)
          gsp_pkg::DR_RS:    state_d = gsp_pkg::ST_COUNT;
          gsp_pkg::DR_MEAN:  state_d = gsp_pkg::ST_DIV;
          gsp_pkg::DR_RATIO: state_d = gsp_pkg::ST_LOG_NORM;
          gsp_pkg::DR_SLOPE: state_d = gsp_pkg::ST_LOG_NORM;
          default:           state_d = gsp_pkg::ST_IDLE;
        endcase
      end
      gsp_pkg::ST_COUNT: state_d = grp_done ? gsp_pkg::ST_DIV : gsp_pkg::ST_IDLE;
      gsp_pkg::ST_LOG_NORM:
        if (m_q[30]) state_d = gsp_pkg::ST_LOG_SQ;
      gsp_pkg::ST_LOG_SQ:
        if (sq_last) state_d = gsp_pkg::ST_LOG_SCALE;
      gsp_pkg::ST_LOG_SCALE: state_d = gsp_pkg::ST_LOG_END;
      gsp_pkg::ST_LOG_END: begin
        unique case (tgt_q)
          gsp_pkg::LT_Y1:    state_d = no_fit ? gsp_pkg::ST_DONE : gsp_pkg::ST_DIV;
          gsp_pkg::LT_RATIO: state_d = gsp_pkg::ST_WM_LO;
          gsp_pkg::LT_CAND:
            state_d = (bit_q == 5'd0) ? gsp_pkg::ST_DONE : gsp_pkg::ST_LOG_NORM;
          default:           state_d = gsp_pkg::ST_LOG_NORM;
        endcase
      end
      gsp_pkg::ST_WM_LO: state_d = gsp_pkg::ST_WM_HI;
      gsp_pkg::ST_WM_HI: state_d = gsp_pkg::ST_WM_END;
      gsp_pkg::ST_WM_END:
        state_d = (wm_q == gsp_pkg::WM_COORD) ? gsp_pkg::ST_WM_LO : gsp_pkg::ST_LOG_NORM;
      gsp_pkg::ST_DONE:
        if (out_free) state_d = gsp_pkg::ST_IDLE;
      default: state_d = gsp_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o      = (state_q == gsp_pkg::ST_IDLE);
    out_valid_o     = out_valid_q;
    concentration_o = out_conc_q;
    mean_kohm_o     = out_mean_q;
    channel_out_o   = out_chan_q;
    status_o        = out_stat_q;
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // fixed helper terms
  assign dv_shift = {rem_q, quo_q[DVD_W-1]};
  assign dv_ge    = (dv_shift >= {1'b0, dvs_q});
  assign sq       = mul_p[61:30];
  assign pexp     = 6'(p_q) - (((tgt_q == gsp_pkg::LT_Y0) || (tgt_q == gsp_pkg::LT_Y1) ||
                               (tgt_q == gsp_pkg::LT_RATIO)) ? 6'd8 : 6'd0);
  assign l2       = {pexp, frac_q};
  assign l2mag    = pexp[5] ? (22'd0 - l2) : l2;
  assign pr       = mul_p[52:32];
  assign dy       = {res_q[LOG_W-1], res_q} - {ly0_q[LOG_W-1], ly0_q};
  assign dx       = {lx1_q[LOG_W-1], lx1_q} - {lx0_q[LOG_W-1], lx0_q};
  assign dymag    = dy[21] ? (22'd0 - dy) : dy;
  assign dxmag    = dx[21] ? (22'd0 - dx) : dx;
  assign opv      = (wm_q == gsp_pkg::WM_COORD) ? lx0_q : lr_q;
  assign opneg    = opv[LOG_W-1];
  assign opmag    = opneg ? (LOG_W'(0) - opv) : opv;
  assign tmag     = acc_q[55:16];
  assign term     = (sneg_q ^ opneg) ? (E_W'(0) - E_W'(tmag)) : E_W'(tmag);
  assign cand     = conc_q | (20'd1 << bit_q);
  assign keep     = ($signed({{(E_W-LOG_W){res_q[LOG_W-1]}}, res_q}) <= e_q);
  assign cnew     = keep ? cand : conc_q;

  // datapath
  always_comb begin
    raw_d = raw_q;  chan_d = chan_q;  cnt_d = cnt_q;  sum_d = sum_q;  zero_d = zero_q;
    rem_d = rem_q;  quo_d = quo_q;  dvs_d = dvs_q;  step_d = step_q;  ret_d = ret_q;
    m_d = m_q;  p_d = p_q;  frac_d = frac_q;  res_d = res_q;  tgt_d = tgt_q;
    lx0_d = lx0_q;  lx1_d = lx1_q;  ly0_d = ly0_q;  lr_d = lr_q;
    mean_d = mean_q;  ratio_d = ratio_q;  smag_d = smag_q;  sneg_d = sneg_q;
    acc_d = acc_q;  wm_d = wm_q;  e_d = e_q;  conc_d = conc_q;  bit_d = bit_q;
    mul_a = 32'd0;  mul_b = 32'd0;
    do_div = 1'b0;  l_dvd = '0;  l_dvs = '0;  l_ret = gsp_pkg::DR_RS;
    do_log = 1'b0;  l_x = '0;  l_tgt = gsp_pkg::LT_X0;

    case (state_q)
      gsp_pkg::ST_IDLE:
        if (in_acc) begin
          raw_d  = sample_i;
          chan_d = channel_i;
          if (sample_i == 10'd0) zero_d = 1'b1;
        end
      // numerator load * (1023 - raw) * 256 over raw * 1000
      gsp_pkg::ST_RS_MUL: begin
        mul_a  = 32'(load_q);
        mul_b  = 32'(10'd1023 - raw_q);
        do_div = 1'b1;
        l_dvd  = {6'd0, mul_p[25:0], 8'd0};
        l_dvs  = 20'(raw_q) * 20'd1000;
        l_ret  = gsp_pkg::DR_RS;
      end
      // one restoring step
      gsp_pkg::ST_DIV: begin
        rem_d  = dv_ge ? DVS_W'(dv_shift - {1'b0, dvs_q}) : dv_shift[DVS_W-1:0];
        quo_d  = {quo_q[DVD_W-2:0], dv_ge};
        step_d = step_q + 6'd1;
      end
      gsp_pkg::ST_DIV_END: begin
        case (ret_q)
          gsp_pkg::DR_RS: sum_d = sum_q + quo_q[31:0];
          gsp_pkg::DR_MEAN: begin
            mean_d = quo_q[31:0];
            do_div = 1'b1;
            l_dvd  = {quo_q[31:0], 8'd0};
            l_dvs  = (r0_q == 16'd0) ? 20'd1 : 20'(r0_q);
            l_ret  = gsp_pkg::DR_RATIO;
          end
          gsp_pkg::DR_RATIO: begin
            if (quo_q == '0) ratio_d = 16'd1;
            else if (quo_q > DVD_W'(16'hFFFF)) ratio_d = 16'hFFFF;
            else ratio_d = quo_q[15:0];
            do_log = 1'b1;
            l_x    = (x0_q == 16'd0) ? 20'd1 : 20'(x0_q);
            l_tgt  = gsp_pkg::LT_X0;
          end
          default: begin
            smag_d = quo_q[35:0];
            do_log = 1'b1;
            l_x    = 20'(ratio_q);
            l_tgt  = gsp_pkg::LT_RATIO;
          end
        endcase
      end
      gsp_pkg::ST_COUNT: begin
        cnt_d = cnt_q + 3'd1;
        if (grp_done) begin
          do_div = 1'b1;
          l_dvd  = DVD_W'(sum_q);
          l_dvs  = DVS_W'(SAMPLES);
          l_ret  = gsp_pkg::DR_MEAN;
        end
      end
      // bring the leading one to bit 30
      gsp_pkg::ST_LOG_NORM: begin
        if (m_q[30]) begin
          step_d = 6'd0;
        end else if (m_q[30:23] == 8'd0) begin
          m_d = {m_q[22:0], 8'd0};
          p_d = p_q - 5'd8;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          p_d = p_q - 5'd1;
        end
      end
      // one fraction bit per squaring
      gsp_pkg::ST_LOG_SQ: begin
        mul_a  = {1'b0, m_q};
        mul_b  = {1'b0, m_q};
        m_d    = sq[31] ? sq[31:1] : sq[30:0];
        frac_d = {frac_q[14:0], sq[31]};
        step_d = step_q + 6'd1;
      end
      // log2 to log10, truncated toward zero
      gsp_pkg::ST_LOG_SCALE: begin
        mul_a = 32'(l2mag);
        mul_b = gsp_pkg::LOG10_2_Q32;
        res_d = pexp[5] ? (LOG_W'(0) - pr) : pr;
      end
      gsp_pkg::ST_LOG_END: begin
        case (tgt_q)
          gsp_pkg::LT_X0: begin
            lx0_d  = res_q;
            do_log = 1'b1;
            l_x    = (x1_q == 16'd0) ? 20'd1 : 20'(x1_q);
            l_tgt  = gsp_pkg::LT_X1;
          end
          gsp_pkg::LT_X1: begin
            lx1_d  = res_q;
            do_log = 1'b1;
            l_x    = (y0_q == 16'd0) ? 20'd1 : 20'(y0_q);
            l_tgt  = gsp_pkg::LT_Y0;
          end
          gsp_pkg::LT_Y0: begin
            ly0_d  = res_q;
            do_log = 1'b1;
            l_x    = (y1_q == 16'd0) ? 20'd1 : 20'(y1_q);
            l_tgt  = gsp_pkg::LT_Y1;
          end
          gsp_pkg::LT_Y1:
            if (!no_fit) begin
              sneg_d = dy[21] ^ dx[21];
              do_div = 1'b1;
              l_dvd  = {2'd0, dymag, 16'd0};
              l_dvs  = DVS_W'(dxmag);
              l_ret  = gsp_pkg::DR_SLOPE;
            end
          gsp_pkg::LT_RATIO: begin
            lr_d = res_q;
            wm_d = gsp_pkg::WM_COORD;
          end
          default: begin
            conc_d = cnew;
            if (bit_q != 5'd0) begin
              bit_d  = bit_q - 5'd1;
              do_log = 1'b1;
              l_x    = cnew | (20'd1 << (bit_q - 5'd1));
              l_tgt  = gsp_pkg::LT_CAND;
            end
          end
        endcase
      end
      // slope times log, split in two partial products
      gsp_pkg::ST_WM_LO: begin
        mul_a = 32'(smag_q[17:0]);
        mul_b = 32'(opmag);
        acc_d = ACC_W'(mul_p[37:0]);
      end
      gsp_pkg::ST_WM_HI: begin
        mul_a = 32'(smag_q[35:18]);
        mul_b = 32'(opmag);
        acc_d = acc_q + {mul_p[37:0], 18'd0};
      end
      gsp_pkg::ST_WM_END: begin
        if (wm_q == gsp_pkg::WM_COORD) begin
          e_d  = $signed({{(E_W-LOG_W){ly0_q[LOG_W-1]}}, ly0_q}) - $signed(term);
          wm_d = gsp_pkg::WM_E;
        end else begin
          e_d    = e_q + $signed(term);
          conc_d = 20'd0;
          bit_d  = 5'd19;
          do_log = 1'b1;
          l_x    = 20'h80000;
          l_tgt  = gsp_pkg::LT_CAND;
        end
      end
      gsp_pkg::ST_DONE:
        if (out_free) begin
          cnt_d  = 3'd0;
          sum_d  = 32'd0;
          zero_d = 1'b0;
        end
      default: ;
    endcase

    // unit launches
    if (do_div) begin
      rem_d  = '0;
      quo_d  = l_dvd;
      dvs_d  = l_dvs;
      step_d = 6'd0;
      ret_d  = l_ret;
    end
    if (do_log) begin
      m_d    = 31'(l_x);
      p_d    = 5'd30;
      frac_d = 16'd0;
      tgt_d  = l_tgt;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsp_pkg::ST_IDLE;
      cnt_q       <= 3'd0;
      sum_q       <= 32'd0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      zero_q      <= zero_d;
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;  chan_q <= chan_d;
    rem_q <= rem_d;  quo_q <= quo_d;  dvs_q <= dvs_d;  step_q <= step_d;  ret_q <= ret_d;
    m_q <= m_d;  p_q <= p_d;  frac_q <= frac_d;  res_q <= res_d;  tgt_q <= tgt_d;
    lx0_q <= lx0_d;  lx1_q <= lx1_d;  ly0_q <= ly0_d;  lr_q <= lr_d;
    mean_q <= mean_d;  ratio_q <= ratio_d;  smag_q <= smag_d;  sneg_q <= sneg_d;
    acc_q <= acc_d;  wm_q <= wm_d;  e_q <= e_d;  conc_q <= conc_d;  bit_q <= bit_d;
    if (load_out) begin
      out_conc_q <= (stat == gsp_pkg::STAT_OK) ? conc_q : 20'd0;
      out_mean_q <= (mean_q > 32'hFFFFFF) ? 24'hFFFFFF : mean_q[23:0];
      out_chan_q <= chan_q;
      out_stat_q <= stat;
    end
  end

  // checks
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gsp_pkg::ST_DIV |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gsp_pkg::ST_LOG_SQ |-> m_q[30])
    else $error("log mantissa not normalized");

  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> cnt_q == 3'(SAMPLES))
    else $error("result issued before group complete");

  a_stat_conc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gsp_pkg::STAT_OK |-> concentration_o == 20'd0)
    else $error("concentration given with error status");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready while an item is in work");

endmodule

`default_nettype wire
